/* src/graph_mean_aggregate_root_relu_assert.svh */
// Assertion macros for the mean aggregation block.
// Used by the top level; they expand to nothing when SYNTHESIS is defined.
`ifndef GRAPH_MEAN_AGGREGATE_ROOT_RELU_ASSERT_SVH
`define GRAPH_MEAN_AGGREGATE_ROOT_RELU_ASSERT_SVH
`ifndef SYNTHESIS
`define GMAR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GMAR_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);
`else
`define GMAR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define GMAR_ASSERT_AFTER_RESET(label, clk, rst, cons, msg)
`endif
`endif

/* src/gmar_pkg.sv */
// Shared types and constants for the mean aggregation block.
// No dependencies; imported by every module of the block but gmar_ram.
`timescale 1ns / 1ps
package gmar_pkg;

   localparam int CFG_W       = 9;
   localparam int CH_W        = 8;
   localparam int VAL_W       = 32;
   localparam int SUM_W       = 48;
   localparam int CNT_W       = 16;
   localparam int QUO_W       = SUM_W + 1;
   localparam int STEP_W      = 6;
   localparam int DATA_W      = 40;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [CFG_W-1:0] CHANNELS_RESET = 9'd64;
   localparam logic [CNT_W-1:0] COUNT_MAX      = 16'hFFFF;

   typedef enum logic {
      CMD_NEIGHBOR = 1'b0,
      CMD_ROOT     = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [CH_W-1:0]          channel;
      logic signed [VAL_W-1:0]  value;
      logic                     last;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXEC,
      BK_DIV,
      BK_OUT
   } back_state_type;

endpackage

/* src/gmar_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gmar_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* src/gmar_front.sv */
// Front end: accepts request words, drops out-of-range channels, marks the
// last channel and queues the items for the back end. Depends on gmar_pkg.
`timescale 1ns / 1ps
module gmar_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gmar_pkg::CFG_W-1:0]    eff_channels,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [gmar_pkg::DATA_W-1:0]   req_tdata,
   input  logic                          req_tuser,
   output gmar_pkg::item_type            head,
   output logic                          head_valid,
   input  logic                          head_pop
);
   import gmar_pkg::*;

   item_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       fill_ff, fill_in;
   logic [CH_W-1:0]       channel;
   logic                  in_range;
   logic                  push;
   logic                  pop;
   item_type              item;

   assign channel    = req_tdata[CH_W-1:0];
   assign in_range   = {1'b0, channel} < eff_channels;
   assign req_tready = fill_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready && in_range;
   assign head_valid = fill_ff != '0;
   assign pop        = head_pop && head_valid;
   assign head       = queue_ff[rd_ptr_ff];

   always_comb begin
      item.cmd     = cmd_type'(req_tuser);
      item.channel = channel;
      item.value   = signed'(req_tdata[CH_W +: VAL_W]);
      item.last    = {1'b0, channel} == (eff_channels - 9'd1);
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

/* src/gmar_div.sv */
// Signed restoring divider, one quotient bit per cycle, rounding toward zero.
// Divides a 48-bit signed sum by a 16-bit unsigned nonzero count. Uses gmar_pkg.
`timescale 1ns / 1ps
module gmar_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [gmar_pkg::SUM_W-1:0]   dividend,
   input  logic [gmar_pkg::CNT_W-1:0]          divisor,
   output logic                                done,
   output logic signed [gmar_pkg::QUO_W-1:0]   quotient
);
   import gmar_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [CNT_W:0]       rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [CNT_W:0]       rem_shift;
   logic                 fits;

   assign rem_shift = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W - 1);
         rem_in  = '0;
         quo_in  = dividend[SUM_W-1] ? -dividend : dividend;
         den_in  = divisor;
         neg_in  = dividend[SUM_W-1];
      end else if (busy_ff) begin
         rem_in  = fits ? rem_shift - {1'b0, den_ff} : rem_shift;
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -signed'({1'b0, quo_ff}) : signed'({1'b0, quo_ff});

endmodule

/* src/gmar_back.sv */
// Back end: per-channel sum store, neighbor count, divider and result register.
// Depends on gmar_pkg, gmar_ram and gmar_div.
`timescale 1ns / 1ps
module gmar_back #(
   parameter int DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gmar_pkg::item_type            head,
   input  logic                          head_valid,
   output logic                          head_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [gmar_pkg::DATA_W-1:0]   rsp_tdata,
   output logic                          rsp_tlast
);
   import gmar_pkg::*;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   back_state_type             state_ff, state_in;
   item_type                   item_ff;
   logic [DEPTH-1:0]           valid_ff;
   logic                       rd_valid_ff;
   logic [CNT_W-1:0]           count_ff;
   logic signed [QUO_W-1:0]    mean_ff;
   logic                       out_valid_ff;
   logic [VAL_W-1:0]           out_value_ff;
   logic [CH_W-1:0]            out_channel_ff;
   logic                       out_last_ff;

   logic                       rd_en;
   logic                       wr_en;
   logic                       div_start;
   logic                       load_out;
   logic [ADDR_W-1:0]          rd_addr;
   logic [ADDR_W-1:0]          item_addr;
   logic [SUM_W-1:0]           ram_rdata;
   logic signed [SUM_W-1:0]    sum_cur;
   logic signed [SUM_W:0]      sum_wide;
   logic [SUM_W-1:0]           sum_new;
   logic                       div_done;
   logic signed [QUO_W-1:0]    div_quot;
   logic signed [QUO_W:0]      result_wide;
   logic [VAL_W-1:0]           result;

   assign rd_addr   = head.channel[ADDR_W-1:0];
   assign item_addr = item_ff.channel[ADDR_W-1:0];

   gmar_ram #(
      .WIDTH (SUM_W),
      .DEPTH (DEPTH)
   ) u_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (item_addr),
      .wr_data (sum_new),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   gmar_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_cur),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // A channel that was never written since the last clear reads as zero.
   assign sum_cur  = rd_valid_ff ? signed'(ram_rdata) : '0;
   assign sum_wide = {sum_cur[SUM_W-1], sum_cur} + (SUM_W+1)'(item_ff.value);

   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_new = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_new = sum_wide[SUM_W-1:0];
      end
   end

   assign result_wide = {mean_ff[QUO_W-1], mean_ff} + (QUO_W+1)'(item_ff.value);

   always_comb begin
      if (result_wide[QUO_W]) begin
         result = '0;
      end else if (result_wide[QUO_W-1:VAL_W-1] != '0) begin
         result = {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         result = result_wide[VAL_W-1:0];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head_valid) state_in = BK_EXEC;
         end
         BK_EXEC: begin
            if (item_ff.cmd == CMD_NEIGHBOR) begin
               state_in = BK_IDLE;
            end else if (count_ff == '0) begin
               state_in = BK_OUT;
            end else begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (div_done) state_in = BK_OUT;
         end
         BK_OUT: begin
            if (load_out) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         BK_IDLE: rd_en = head_valid;
         BK_EXEC: begin
            wr_en     = item_ff.cmd == CMD_NEIGHBOR;
            div_start = (item_ff.cmd == CMD_ROOT) && (count_ff != '0);
         end
         BK_DIV: ;
         BK_OUT: load_out = !out_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign head_pop = rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            valid_ff[item_addr] <= 1'b1;
            if (item_ff.last && count_ff != COUNT_MAX) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if (load_out) begin
            out_valid_ff <= 1'b1;
            if (item_ff.last) begin
               valid_ff <= '0;
               count_ff <= '0;
            end
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         item_ff     <= head;
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (state_ff == BK_EXEC) begin
         mean_ff <= '0;
      end else if (div_done) begin
         mean_ff <= div_quot;
      end
      if (load_out) begin
         out_value_ff   <= result;
         out_channel_ff <= item_ff.channel;
         out_last_ff    <= item_ff.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_channel_ff, out_value_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

/* src/graph_mean_aggregate_root_relu.sv */
// Top level of the graph mean aggregation block with root add and ReLU.
// Depends on gmar_pkg, gmar_front, gmar_back and the assertion header.
`timescale 1ns / 1ps
`include "graph_mean_aggregate_root_relu_assert.svh"
// Usage:
// The req channel carries one feature word per beat: tdata holds the channel
// index in bits 7:0 and the signed Q16.16 value in bits 39:8, and tuser says
// whether the word belongs to a neighbor row (0) or to the node's root row (1).
// Neighbor words are summed per channel; the word on the last channel of a row
// counts one neighbor. Each root word gives one rsp word: tdata holds the
// ReLU of the mean plus root in bits 31:0 and the channel in bits 39:32, and
// tlast marks the last channel, after which the sums and the count clear.
// Words whose channel is not below the channel count are dropped silently.
// A four-word queue sits between the accepting front end and the back end.
// The back end handles one word at a time: a neighbor word does a
// read-modify-write of the sum memory, a root word of a node without
// neighbors goes straight to the output step, and a root word with neighbors
// runs the 48-step bit-serial divider. While a result waits on rsp_tready,
// the back end goes on with neighbor words and with the division of the next
// root word; it holds in its output step until the waiting result is taken.
// Synchronous reset empties the queue and result register, zeroes the sums
// and count through per-channel valid bits at once, and sets the channel count
// to 64. Only the user keeps csr port writes of the channel count to idle.
module graph_mean_aggregate_root_relu #(
   parameter int MAX_CHANNELS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   // csr_wdata: channel count (8:0)
   input  logic                          csr_wen,
   input  logic [gmar_pkg::CFG_W-1:0]    csr_wdata,
   // req_tdata: channel (7:0), value (39:8)
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [gmar_pkg::DATA_W-1:0]   req_tdata,
   // req_tuser: cmd (0), 0 neighbor, 1 root
   input  logic                          req_tuser,
   // rsp_tdata: out_value (31:0), out_channel (39:32)
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [gmar_pkg::DATA_W-1:0]   rsp_tdata,
   output logic                          rsp_tlast
);
   import gmar_pkg::*;

   // Only 256 channels are addressable by the 8-bit channel field.
   localparam int DEPTH = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;

   logic [CFG_W-1:0] channels_ff;
   logic [CFG_W-1:0] eff_channels;
   item_type         head;
   logic             head_valid;
   logic             head_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         channels_ff <= CHANNELS_RESET;
      end else if (csr_wen) begin
         channels_ff <= csr_wdata;
      end
   end

   // A count of zero acts as one; a count above MAX_CHANNELS is clipped to it.
   always_comb begin
      eff_channels = channels_ff;
      if (channels_ff == '0) begin
         eff_channels = 9'd1;
      end else if (int'(channels_ff) > MAX_CHANNELS) begin
         eff_channels = CFG_W'(MAX_CHANNELS);
      end
   end

   gmar_front u_front (
      .clock        (clock),
      .reset        (reset),
      .eff_channels (eff_channels),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .head         (head),
      .head_valid   (head_valid),
      .head_pop     (head_pop)
   );

   gmar_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The ReLU never lets a negative value out.
   `GMAR_ASSERT_IMPLY(a_rsp_nonneg, clock, reset, rsp_tvalid, !rsp_tdata[VAL_W-1], "negative result")
   // Every result belongs to a channel below the channel count.
   `GMAR_ASSERT_IMPLY(a_rsp_in_range, clock, reset, rsp_tvalid, {1'b0, rsp_tdata[DATA_W-1:VAL_W]} < eff_channels, "result channel out of range")
   // The last flag sits exactly on the final channel of the row.
   `GMAR_ASSERT_IMPLY(a_rsp_last, clock, reset, rsp_tvalid, rsp_tlast == ({1'b0, rsp_tdata[DATA_W-1:VAL_W]} == eff_channels - 9'd1), "last flag on wrong channel")
   // Reset leaves no result pending and restores the channel count.
   `GMAR_ASSERT_AFTER_RESET(a_reset_state, clock, reset, !rsp_tvalid && channels_ff == CHANNELS_RESET, "bad state after reset")

endmodule

/* tb/mean_relu_checker.sv */
// Checker for the graph mean aggregation block: watches the csr, req and rsp ports,
// predicts every rsp word from the accepted req words and compares field by field.
// Depends on gmar_pkg only.
`timescale 1ns / 1ps
module mean_relu_checker
   import gmar_pkg::*;
#(
   parameter int MAX_CHANNELS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic [CFG_W-1:0]   csr_wdata,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [DATA_W-1:0]  req_tdata,
   input  logic               req_tuser,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [DATA_W-1:0]  rsp_tdata,
   input  logic               rsp_tlast,
   output int                 fail_count,
   output int                 pending_results,
   output int                 used_words
);

   localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_LO = -SUM_HI - 64'sd1;
   localparam longint OUT_HI = 64'sd2147483647;

   typedef struct {
      logic [VAL_W-1:0] value;
      logic [CH_W-1:0]  channel;
      logic             last;
   } relu_word_t;

   longint           channel_total [MAX_CHANNELS];
   int unsigned      rows_seen;
   logic [CFG_W-1:0] channel_setting;
   relu_word_t       expected_relu_q [$];
   int               mismatches = 0;
   int               words_in_range = 0;

   assign fail_count      = mismatches;
   assign pending_results = expected_relu_q.size();
   assign used_words      = words_in_range;

   task automatic clear_node();
      foreach (channel_total[i]) channel_total[i] = 0;
      rows_seen = 0;
   endtask

   // Neighbor words accumulate with 48-bit saturation; root words produce the
   // truncated mean plus root, clipped to 32 bits and passed through ReLU.
   task automatic predict_word(input cmd_type cmd, input logic [CH_W-1:0] ch,
                               input logic signed [VAL_W-1:0] val);
      int unsigned eff;
      longint      acc;
      logic        at_end;
      relu_word_t  w;
      eff = (channel_setting == 0) ? 1 : channel_setting;
      if (eff > MAX_CHANNELS) eff = MAX_CHANNELS;
      if (ch >= eff) return;
      words_in_range++;
      at_end = (ch == eff - 1);
      if (cmd == CMD_NEIGHBOR) begin
         acc = channel_total[ch] + longint'(val);
         if (acc > SUM_HI) acc = SUM_HI;
         if (acc < SUM_LO) acc = SUM_LO;
         channel_total[ch] = acc;
         if (at_end && rows_seen < COUNT_MAX) rows_seen++;
      end else begin
         acc = longint'(val);
         if (rows_seen != 0) acc += channel_total[ch] / longint'(rows_seen);
         if (acc > OUT_HI) acc = OUT_HI;
         if (acc < 0) acc = 0;
         w.value   = acc[VAL_W-1:0];
         w.channel = ch;
         w.last    = at_end;
         expected_relu_q.push_back(w);
         if (at_end) clear_node();
      end
   endtask

   always @(posedge clock) begin
      relu_word_t w;
      if (reset) begin
         clear_node();
         channel_setting = CHANNELS_RESET;
         expected_relu_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_relu_q.size() == 0) begin
               $error("rsp word with no expected result: tdata %h tlast %b",
                      rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               w = expected_relu_q.pop_front();
               if (rsp_tdata[VAL_W-1:0] !== w.value) begin
                  $error("out_value: expected %h, got %h", w.value, rsp_tdata[VAL_W-1:0]);
                  mismatches++;
               end
               if (rsp_tdata[VAL_W +: CH_W] !== w.channel) begin
                  $error("out_channel: expected %0d, got %0d", w.channel,
                         rsp_tdata[VAL_W +: CH_W]);
                  mismatches++;
               end
               if (rsp_tlast !== w.last) begin
                  $error("last: expected %b, got %b", w.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
         if (csr_wen) channel_setting = csr_wdata;
         if (req_tvalid && req_tready)
            predict_word(cmd_type'(req_tuser), req_tdata[CH_W-1:0], req_tdata[CH_W +: VAL_W]);
      end
   end

endmodule

/* tb/graph_mean_aggregate_root_relu_tb.sv */
// Testbench top for the graph mean aggregation block with root add and ReLU.
// Drives stimulus and gives the verdict; depends on gmar_pkg, the block and mean_relu_checker.
`timescale 1ns / 1ps
module graph_mean_aggregate_root_relu_tb;
   import gmar_pkg::*;

   localparam int MAX_CHANNELS  = 256;
   // Words inside the channel range that the random part aims for.
   localparam int TARGET_WORDS  = 420;
   // Cycles allowed for words that give no result to leave the block's queue.
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int CYCLE_LIMIT   = 400_000;

   logic              clock;
   logic              reset;
   logic              csr_wen;
   logic [CFG_W-1:0]  csr_wdata;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tlast;

   int fail_count;
   int pending_results;
   int used_words;
   int cycle_count = 0;
   // When set, neither side inserts idle cycles.
   bit calm;
   // Row length that the stimulus builds, i.e. the channel count as the block sees it.
   int channels_now;

   graph_mean_aggregate_root_relu #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   mean_relu_checker #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) relu_check (
      .clock           (clock),
      .reset           (reset),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .used_words      (used_words)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog. The slowest correct run stays far below this limit, so reaching
   // it means a word was lost or a handshake hung.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** graph_mean_aggregate_root_relu: FAILED **");
         $finish;
      end
   end

   // Result side. The receiver drops tready in random bursts, and
   // stays ready the whole time once the run goes calm.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 14);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Feature values: the two extremes and zero show up often, the rest is a mix
   // of full-range words and small Q16.16 values around zero so that the means
   // and the root cancel in interesting ways.
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3, 4, 5: return $urandom;
         default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      endcase
   endfunction

   // Presents one word on the req channel and returns at the falling edge after
   // it was accepted. tvalid stays high into the next call unless a gap is due.
   task automatic send_word(input cmd_type cmd, input logic [CH_W-1:0] ch,
                            input logic [VAL_W-1:0] val);
      int gap;
      if (!calm && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {val, ch};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Lets the block go idle: every root word has produced its result, and the
   // neighbor words still in the queue have had time to retire.
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // The csr register is only ever written with the block idle.
   task automatic write_channels(input int setting);
      hold_until_drained();
      csr_wen   <= 1'b1;
      csr_wdata <= CFG_W'(setting);
      @(negedge clock);
      csr_wen   <= 1'b0;
      channels_now = (setting == 0) ? 1 : ((setting > MAX_CHANNELS) ? MAX_CHANNELS : setting);
   endtask

   // One feature row in channel order. Now and then a stray word with random
   // command and channel slips in, and now and then an element goes missing,
   // which breaks the row: a missing last channel leaves the row uncounted.
   task automatic send_row(input cmd_type cmd);
      for (int ch = 0; ch < channels_now; ch++) begin
         if ($urandom_range(0, 24) == 0)
            send_word(cmd_type'($urandom_range(0, 1)), CH_W'($urandom_range(0, 255)),
                      $urandom);
         if ($urandom_range(0, 39) != 0) send_word(cmd, CH_W'(ch), pick_value());
      end
   endtask

   initial begin
      int phase_nodes;
      int rows;
      int setting;
      int random_base;
      int left;
      reset        = 1'b1;
      csr_wen      = 1'b0;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      calm         = 1'b0;
      channels_now = CHANNELS_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset channel count of 64. A root word with no neighbors is just the
      // ReLU of the root; channel 64 and above are dropped for either command.
      send_word(CMD_ROOT, 0, 32'hFFFF_FFFB);
      send_word(CMD_ROOT, 64, 32'h0001_0000);
      send_word(CMD_NEIGHBOR, 200, 32'h7FFF_FFFF);
      send_word(CMD_ROOT, 63, 32'h7FFF_FFFF);

      // A count of zero behaves as one channel. Two rows summing to -3 give a
      // mean of -1, rounded toward zero rather than down, so the result is 1.
      write_channels(0);
      send_word(CMD_NEIGHBOR, 0, 32'hFFFF_FFFD);
      send_word(CMD_NEIGHBOR, 0, 32'h0000_0000);
      send_word(CMD_NEIGHBOR, 1, 32'h0000_0007);
      send_word(CMD_ROOT, 0, 32'h0000_0002);
      send_word(CMD_ROOT, 1, 32'h0000_0005);

      // All nine register bits set: the count clamps to 256 channels.
      write_channels(511);
      send_word(CMD_NEIGHBOR, 255, 32'h8000_0000);
      send_word(CMD_ROOT, 128, 32'h1234_5678);
      send_word(CMD_ROOT, 255, 32'h7FFF_FFFF);

      // Full 256 channels; the last channel's result saturates at the top.
      write_channels(256);
      send_word(CMD_NEIGHBOR, 0, 32'h0003_0000);
      send_word(CMD_NEIGHBOR, 255, 32'h7FFF_FFFF);
      send_word(CMD_ROOT, 0, 32'hFFFF_0000);
      send_word(CMD_ROOT, 255, 32'h7FFF_FFFF);

      // Two channels, negative sums, truncating division on both.
      write_channels(2);
      send_word(CMD_NEIGHBOR, 0, 32'hFFFF_FFF9);
      send_word(CMD_NEIGHBOR, 1, 32'h0000_0005);
      send_word(CMD_NEIGHBOR, 0, 32'h0000_0002);
      send_word(CMD_NEIGHBOR, 1, 32'hFFFF_FFF8);
      send_word(CMD_ROOT, 0, 32'h0000_0005);
      send_word(CMD_ROOT, 1, 32'h0000_0000);

      // Random part: phases of nodes with random content, sometimes broken, under a
      // random channel count, small counts most of the time. Every phase starts
      // from an idle block, so the sender also waits out all results there. The
      // last stretch runs without idling on either side.
      random_base = used_words;
      left        = TARGET_WORDS;
      while (left > 0) begin
         case ($urandom_range(0, 15))
            0: setting = 0;
            1: setting = $urandom_range(257, 511);
            2: setting = 256;
            3: setting = $urandom_range(9, 64);
            default: setting = $urandom_range(1, 8);
         endcase
         // A row never gets longer than what is left of the word budget.
         if (((setting == 0) ? 1 : ((setting > MAX_CHANNELS) ? MAX_CHANNELS : setting)) > left)
            setting = $urandom_range(1, (left < 8) ? left : 8);
         write_channels(setting);
         phase_nodes = (channels_now > 64) ? 1 : $urandom_range(1, 4);
         repeat (phase_nodes) begin
            rows = (channels_now > 64) ? $urandom_range(0, 1) : $urandom_range(0, 4);
            // Neighbor rows are trimmed so that the node fits in the budget.
            if ((rows + 1) * channels_now > left) rows = left / channels_now - 1;
            if (rows >= 0) begin
               repeat (rows) send_row(CMD_NEIGHBOR);
               send_row(CMD_ROOT);
            end
            left = TARGET_WORDS - (used_words - random_base);
            calm = (used_words - random_base) > (TARGET_WORDS * 85 / 100);
         end
      end

      req_tvalid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && pending_results != 0; n++) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_results != 0)
         $error("%0d expected results never arrived", pending_results);
      if (fail_count == 0 && pending_results == 0) begin
         $display("** graph_mean_aggregate_root_relu: PASSED **");
      end else begin
         $display("** graph_mean_aggregate_root_relu: FAILED **");
      end
      $finish;
   end

endmodule
